// File: rtl/core/ofb_pkg.sv
// Shared constants and widths for the overlapping frame buffer.
package ofb_pkg;

   localparam int FIFO_DEPTH  = 1024;
   localparam int FRAME_MAX   = 64;
   localparam int SAMPLE_BITS = 24;

   localparam int RING_AW  = $clog2(FIFO_DEPTH);
   localparam int FILL_W   = RING_AW + 1;
   localparam int FRAME_AW = $clog2(FRAME_MAX);
   localparam int CNT_W    = $clog2(FILL_W);

   localparam int HOP_W = 6;
   localparam int LEN_W = 7;
   localparam int POS_W = 6;

   localparam int REQ_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((SAMPLE_BITS + POS_W + 7) / 8) * 8;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_HOP_SIZE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LENGTH = 1'b1;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [HOP_W-1:0] HOP_RESET = 6'd16;
   localparam logic [LEN_W-1:0] LEN_RESET = 7'd32;

endpackage

// File: rtl/core/ofb_ram.sv
// Generic single write port, single read port RAM with registered read.
module ofb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/overlap_frame_buffer.sv
// Overlapping frame buffer: sample ring FIFO with hop-wise frame read-out.
//
//  channel  dir  fields
//  req_     in   tuser: action; tdata: sample
//  rsp_     out  tuser: frame_ready; tdata: out_sample, position; tlast: last
//  csr_     in   index 0 hop_size, index 1 frame_length
//
// Push: one transaction per cycle while no read is in progress.
// Read: a single not-ready beat when no hop waits; otherwise the remainder of
//   the fill count by the hop is found bit-serially, then S_CONS and S_BASE,
//   and each sample passes S_ISSUE, S_DATA (single read port on the frame store).
// req_tready is low for the whole read; rsp_tready low holds the sequencer.
// Reset is synchronous; the ring store needs no clearing pass, the frame store
//   reads as zero until each entry is written.
module overlap_frame_buffer
   import ofb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // sample
   input  logic                   req_tuser,   // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_sample, position
   output logic                   rsp_tuser,   // frame_ready
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_CONS,
      S_BASE,
      S_ISSUE,
      S_DATA
   } state_type;

   state_type              state_ff;
   logic [HOP_W-1:0]       hop_size_ff;
   logic [LEN_W-1:0]       frame_length_ff;
   logic [RING_AW-1:0]     wr_ptr_ff;
   logic [RING_AW-1:0]     rd_ptr_ff;
   logic [FILL_W-1:0]      fill_ff;
   logic [HOP_W-1:0]       rem_ff;
   logic [CNT_W-1:0]       bit_cnt_ff;
   logic [FILL_W-1:0]      cons_ff;
   logic [RING_AW-1:0]     ring_addr_ff;
   logic [LEN_W-1:0]       idx_ff;
   logic                   sel_ring_ff;
   logic                   fvalid_sel_ff;
   logic [FRAME_MAX-1:0]   fvalid_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_ready_ff;
   logic                   rsp_last_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [POS_W-1:0]       rsp_pos_ff;

   logic [HOP_W-1:0]       h_eff;
   logic [LEN_W-1:0]       len_eff;
   logic [LEN_W-1:0]       hl_min;
   logic [LEN_W:0]         src;
   logic                   src_in_frame;
   logic                   req_fire;
   logic                   push_ok;
   logic                   out_free;
   logic                   is_last;
   logic [HOP_W:0]         trial;
   logic [HOP_W-1:0]       rem_in;
   logic [FILL_W-1:0]      base_sum;
   logic [FILL_W-1:0]      rp_sum;
   logic [RING_AW-1:0]     base_in;
   logic [RING_AW-1:0]     rd_ptr_in;
   logic [SAMPLE_BITS-1:0] elem;
   logic                   emit;
   logic                   rsp_load;
   logic [SAMPLE_BITS-1:0] ring_rd;
   logic [SAMPLE_BITS-1:0] frame_rd;
   logic                   ring_wr_en;
   logic                   ring_rd_en;
   logic                   frame_rd_en;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign push_ok    = fill_ff < FILL_W'(FIFO_DEPTH);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      h_eff = (hop_size_ff == '0) ? HOP_W'(1) : hop_size_ff;
      if (frame_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (frame_length_ff > LEN_W'(FRAME_MAX)) begin
         len_eff = LEN_W'(FRAME_MAX);
      end else begin
         len_eff = frame_length_ff;
      end
      hl_min = (LEN_W'(h_eff) < len_eff) ? LEN_W'(h_eff) : len_eff;
   end

   assign src          = (LEN_W + 1)'(idx_ff) + (LEN_W + 1)'(h_eff);
   assign src_in_frame = src < (LEN_W + 1)'(len_eff);
   assign is_last      = idx_ff == (len_eff - LEN_W'(1));

   // one restoring step of fill_count mod hop
   assign trial  = {rem_ff, fill_ff[bit_cnt_ff]};
   assign rem_in = (trial >= (HOP_W + 1)'(h_eff)) ? HOP_W'(trial - (HOP_W + 1)'(h_eff))
                                                  : HOP_W'(trial);

   always_comb begin
      base_sum = FILL_W'(rd_ptr_ff) + cons_ff - FILL_W'(hl_min);
      rp_sum   = FILL_W'(rd_ptr_ff) + cons_ff;
      base_in  = (base_sum >= FILL_W'(FIFO_DEPTH)) ? RING_AW'(base_sum - FILL_W'(FIFO_DEPTH))
                                                   : RING_AW'(base_sum);
      rd_ptr_in = (rp_sum >= FILL_W'(FIFO_DEPTH)) ? RING_AW'(rp_sum - FILL_W'(FIFO_DEPTH))
                                                  : RING_AW'(rp_sum);
   end

   assign elem = sel_ring_ff ? ring_rd : (fvalid_sel_ff ? frame_rd : '0);
   assign emit = (state_ff == S_DATA) && out_free;
   assign rsp_load = ((state_ff == S_CHECK) && (fill_ff < FILL_W'(h_eff)) && out_free) || emit;

   assign ring_wr_en  = req_fire && (req_tuser == ACT_PUSH) && push_ok;
   assign ring_rd_en  = (state_ff == S_ISSUE) && !src_in_frame;
   assign frame_rd_en = (state_ff == S_ISSUE) && src_in_frame;

   ofb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (FIFO_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_tdata[SAMPLE_BITS-1:0]),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_addr_ff),
      .rd_data (ring_rd)
   );

   ofb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (FRAME_MAX)
   ) u_frame (
      .clock   (clock),
      .wr_en   (emit),
      .wr_addr (idx_ff[FRAME_AW-1:0]),
      .wr_data (elem),
      .rd_en   (frame_rd_en),
      .rd_addr (src[FRAME_AW-1:0]),
      .rd_data (frame_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         hop_size_ff     <= HOP_RESET;
         frame_length_ff <= LEN_RESET;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fill_ff         <= '0;
         fvalid_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_HOP_SIZE:     hop_size_ff     <= csr_data[HOP_W-1:0];
               REG_FRAME_LENGTH: frame_length_ff <= csr_data[LEN_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_tuser == ACT_READ) begin
                     state_ff <= S_CHECK;
                  end else if (push_ok) begin
                     wr_ptr_ff <= (wr_ptr_ff == RING_AW'(FIFO_DEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
                     fill_ff   <= fill_ff + 1'b1;
                  end
               end
            end
            S_CHECK: begin
               if (fill_ff < FILL_W'(h_eff)) begin
                  if (out_free) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_ready_ff  <= 1'b0;
                     rsp_sample_ff <= '0;
                     rsp_pos_ff    <= '0;
                     rsp_last_ff   <= 1'b1;
                     state_ff      <= S_IDLE;
                  end
               end else begin
                  rem_ff     <= '0;
                  bit_cnt_ff <= CNT_W'(FILL_W - 1);
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= rem_in;
               if (bit_cnt_ff == '0) begin
                  state_ff <= S_CONS;
               end else begin
                  bit_cnt_ff <= bit_cnt_ff - 1'b1;
               end
            end
            S_CONS: begin
               cons_ff  <= fill_ff - FILL_W'(rem_ff);
               state_ff <= S_BASE;
            end
            S_BASE: begin
               ring_addr_ff <= base_in;
               rd_ptr_ff    <= rd_ptr_in;
               fill_ff      <= FILL_W'(rem_ff);
               idx_ff       <= '0;
               state_ff     <= S_ISSUE;
            end
            S_ISSUE: begin
               sel_ring_ff   <= !src_in_frame;
               fvalid_sel_ff <= fvalid_ff[src[FRAME_AW-1:0]];
               state_ff      <= S_DATA;
            end
            S_DATA: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_ready_ff  <= 1'b1;
                  rsp_sample_ff <= elem;
                  rsp_pos_ff    <= POS_W'(idx_ff);
                  rsp_last_ff   <= is_last;
                  fvalid_ff[idx_ff[FRAME_AW-1:0]] <= 1'b1;
                  if (sel_ring_ff) begin
                     ring_addr_ff <= (ring_addr_ff == RING_AW'(FIFO_DEPTH - 1)) ? '0
                                                                          : ring_addr_ff + 1'b1;
                  end
                  if (is_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_pos_ff, rsp_sample_ff});
   assign rsp_tuser  = rsp_ready_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: tb/overlap_frame_buffer_tb.sv
// Self-checking testbench for overlap_frame_buffer: pushes and frame reads against a predictor.
`timescale 1ns / 100ps

module overlap_frame_buffer_tb
   import ofb_pkg::*;
;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 16;
   localparam int TAIL_CYCLES = 160;

   typedef struct {
      logic                   ready;
      logic [SAMPLE_BITS-1:0] smp;
      logic [POS_W-1:0]       pos;
      logic                   last;
   } frame_beat_type;

   // predicts the emitted frames from the accepted transactions
   class frame_tracker;
      logic [SAMPLE_BITS-1:0] ring [FIFO_DEPTH];
      logic [SAMPLE_BITS-1:0] frame [FRAME_MAX];
      int unsigned            wr_ptr;
      int unsigned            rd_ptr;
      int unsigned            fill;
      logic [HOP_W-1:0]       hop;
      logic [LEN_W-1:0]       flen;
      frame_beat_type         pending_beats [$];
      int                     errors;

      function new();
         foreach (ring[i]) ring[i] = '0;
         foreach (frame[i]) frame[i] = '0;
         wr_ptr = 0;
         rd_ptr = 0;
         fill   = 0;
         hop    = HOP_RESET;
         flen   = LEN_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_HOP_SIZE:     hop = val[HOP_W-1:0];
            REG_FRAME_LENGTH: flen = val[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned hop_eff();
         return (hop == 0) ? 1 : hop;
      endfunction

      function bit busy();
         return pending_beats.size() != 0;
      endfunction

      function void take_item(logic act, logic [SAMPLE_BITS-1:0] smp);
         int unsigned            h;
         int unsigned            n;
         int unsigned            hops;
         int unsigned            base;
         int unsigned            src;
         logic [SAMPLE_BITS-1:0] nxt [FRAME_MAX];
         frame_beat_type         b;
         if (act == ACT_PUSH) begin
            if (fill < FIFO_DEPTH) begin
               ring[wr_ptr] = smp;
               wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
               fill++;
            end
            return;
         end
         h = hop_eff();
         n = (flen == 0) ? 1 : ((flen > FRAME_MAX) ? FRAME_MAX : flen);
         hops = fill / h;
         if (hops == 0) begin
            b.ready = 1'b0;
            b.smp   = '0;
            b.pos   = '0;
            b.last  = 1'b1;
            pending_beats.push_back(b);
            return;
         end
         // newest whole hop; older hops are skipped
         base = (rd_ptr + (hops - 1) * h) % FIFO_DEPTH;
         for (int i = 0; i < n; i++) begin
            src = i + h;
            if (src < n) nxt[i] = frame[src];
            else nxt[i] = ring[(base + src - n) % FIFO_DEPTH];
         end
         for (int i = 0; i < n; i++) begin
            frame[i] = nxt[i];
            b.ready = 1'b1;
            b.smp   = nxt[i];
            b.pos   = i[POS_W-1:0];
            b.last  = (i + 1 == n);
            pending_beats.push_back(b);
         end
         rd_ptr = (rd_ptr + hops * h) % FIFO_DEPTH;
         fill   = fill - hops * h;
      endfunction

      function void check_beat(logic ready, logic [RSP_TDATA_W-1:0] data, logic last);
         frame_beat_type         e;
         logic [SAMPLE_BITS-1:0] smp;
         logic [POS_W-1:0]       pos;
         smp = data[SAMPLE_BITS-1:0];
         pos = data[SAMPLE_BITS+POS_W-1:SAMPLE_BITS];
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual ready=%0b",
                     $time, ready, " sample=%h pos=%0d last=%0b", smp, pos, last);
            errors++;
            return;
         end
         e = pending_beats.pop_front();
         if (ready !== e.ready) begin
            $display("%0t: frame_ready expected %0b actual %0b", $time, e.ready, ready);
            errors++;
         end
         if (smp !== e.smp) begin
            $display("%0t: out_sample expected %h actual %h", $time, e.smp, smp);
            errors++;
         end
         if (pos !== e.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, e.pos, pos);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   frame_tracker tracker = new();
   bit           steady = 1'b0;
   bit           hold_req = 1'b0;

   overlap_frame_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      logic [31:0] r;
      r = $urandom();
      return r[SAMPLE_BITS-1:0];
   endfunction

   task automatic send_req(input logic act, input logic [SAMPLE_BITS-1:0] smp);
      if (!steady) begin
         while ($urandom_range(99) < 27) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      tracker.take_item(act, smp);
   endtask

   task automatic push_run(input int n);
      repeat (n) send_req(ACT_PUSH, rand_sample());
   endtask

   task automatic read_frame();
      send_req(ACT_READ, rand_sample());
   endtask

   // sender pauses until every frame beat is back, then lets a trailing push finish
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.busy()) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] hop_val,
                             input logic [CSR_DATA_W-1:0] len_val);
      csr_valid <= 1'b1;
      csr_index <= REG_HOP_SIZE;
      csr_data  <= hop_val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(REG_HOP_SIZE, hop_val);
      csr_index <= REG_FRAME_LENGTH;
      csr_data  <= len_val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(REG_FRAME_LENGTH, len_val);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int n_items);
      int unsigned h;
      int          count;
      int          pushes;
      h = tracker.hop_eff();
      count = 0;
      while (count < n_items) begin
         if ($urandom_range(99) < 75) begin
            pushes = h * $urandom_range(0, 3);
            if ($urandom_range(3) == 0) pushes += $urandom_range(0, h - 1);
            push_run(pushes);
            read_frame();
            count += pushes + 1;
         end else begin
            send_req(logic'($urandom_range(1)), rand_sample());
            count++;
         end
         if ($urandom_range(19) == 0) drain();
      end
      drain();
   endtask

   // result side: random back-pressure, plus a long hold-off on request
   initial begin : frame_sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            tracker.check_beat(rsp_tuser, rsp_tdata, rsp_tlast);
         if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 27);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      logic [SAMPLE_BITS-1:0] corner [6];
      corner = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_PUSH;
      csr_valid  <= 1'b0;
      csr_index  <= REG_HOP_SIZE;
      csr_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty read, one short of a hop, then a full hop
      read_frame();
      foreach (corner[i]) send_req(ACT_PUSH, corner[i]);
      push_run(9);
      read_frame();
      push_run(1);
      read_frame();
      drain();

      // zero hop and zero frame length, with a lagging reader
      set_config(7'd0, 7'd0);
      push_run(3);
      read_frame();
      read_frame();
      drain();

      // hop longer than the frame, single and skipped hops
      set_config(7'd10, 7'd4);
      push_run(10);
      read_frame();
      push_run(25);
      read_frame();
      drain();

      // oversized register values
      set_config(7'h7F, 7'h7F);
      push_run(63);
      read_frame();
      push_run(10);
      read_frame();
      drain();

      steady = 1'b1;
      set_config(7'd3, 7'd8);
      random_phase(30);
      steady = 1'b0;

      // long result hold-off while transactions keep coming
      set_config(7'd2, 7'd64);
      hold_req = 1'b1;
      push_run(40);
      read_frame();
      push_run(10);
      read_frame();
      drain();

      set_config(7'd1, 7'd2);
      random_phase(20);
      set_config(7'd7, 7'd64);
      random_phase(25);
      set_config(7'd13, 7'd13);
      random_phase(20);
      set_config(7'd5, 7'd33);
      random_phase(20);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && !tracker.busy()) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
